// ===== rtl/utf8_pkg.sv =====
// shared constants and helper functions for the utf-8 stream decoder
`timescale 1ns / 1ps

package utf8_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned DATA_W = 24;
  localparam int unsigned CNT_W  = 3;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP      = 21'h10FFFF;
  localparam logic [CP_W-1:0] MIN_CP2     = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP3     = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP4     = 21'h010000;

  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // continuation bytes that a lead byte asks for
  function automatic logic [1:0] needed_of(input logic [BYTE_W-1:0] lead);
    logic [1:0] need;
    if (lead[7:5] == 3'b110) begin
      need = NEED_ONE;
    end else if (lead[7:4] == 4'b1110) begin
      need = NEED_TWO;
    end else begin
      need = NEED_THREE;
    end
    return need;
  endfunction

  // overlong and out-of-range check on a completed sequence
  function automatic logic [CP_W-1:0] finish_value(input logic [1:0] need,
                                                   input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] res;
    res = cp;
    unique case (need)
      NEED_ONE:   if (cp < MIN_CP2) res = REPLACEMENT;
      NEED_TWO:   if (cp < MIN_CP3) res = REPLACEMENT;
      default:    if (cp < MIN_CP4 || cp > MAX_CP) res = REPLACEMENT;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/utf8_stream_decoder.sv =====
// utf-8 byte stream to code point decoder, top level
//
//  channel | dir | tdata (low bit up)        | tlast        | tuser
//  s_*     | in  | byte_in[7:0]              | end_of_text  | -
//  m_*     | out | code_point[20:0], 3'b0    | last_of_run  | text_done
//
//  a byte is decoded in the cycle it is taken; its results sit in one output register
//  a byte with zero or one result allows a new byte every cycle while m_tready is high
//  a byte with n results holds the output for n transfers, input waits until the last
//  rst is synchronous and clears the sequence state and the output register's valid flag and count
//  s_tready follows m_tready combinationally while the last result of a byte is pending
`timescale 1ns / 1ps

module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_in[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // code_point[20:0], zero pad[23:21]
  output logic        m_tlast,
  output logic        m_tuser    // text_done
);

  // sequence state
  logic [utf8_pkg::BYTE_W-1:0] held_lead;
  logic [utf8_pkg::CP_W-1:0]   partial_value;
  logic [1:0]                  held_cont;
  logic                        seq_open;

  logic [utf8_pkg::BYTE_W-1:0] held_lead_next;
  logic [utf8_pkg::CP_W-1:0]   partial_value_next;
  logic [1:0]                  held_cont_next;
  logic                        seq_open_next;

  // output register: results left and the value of the final one
  logic                        out_valid;
  logic [utf8_pkg::CNT_W-1:0]  remaining;
  logic [utf8_pkg::CP_W-1:0]   last_value;
  logic                        out_eot;

  logic [utf8_pkg::CNT_W-1:0]  count_next;
  logic [utf8_pkg::CP_W-1:0]   last_value_next;

  logic                        in_xfer;
  logic                        out_xfer;
  logic                        final_res;
  logic                        is_cont;
  logic [1:0]                  need;
  logic [utf8_pkg::CP_W-1:0]   shifted;
  logic [utf8_pkg::CNT_W-1:0]  base;

  assign final_res = (remaining == utf8_pkg::CNT_W'(1));
  assign out_xfer  = out_valid && m_tready;
  assign s_tready  = !out_valid || (m_tready && final_res);
  assign in_xfer   = s_tvalid && s_tready;

  assign is_cont = (s_tdata[7:6] == 2'b10);
  assign need    = utf8_pkg::needed_of(held_lead);
  assign shifted = {partial_value[utf8_pkg::CP_W-7:0], s_tdata[5:0]};
  assign base    = seq_open ? (utf8_pkg::CNT_W'(1) + {1'b0, held_cont}) : '0;

  always_comb begin
    held_lead_next     = held_lead;
    partial_value_next = partial_value;
    held_cont_next     = held_cont;
    seq_open_next      = seq_open;
    count_next         = '0;
    last_value_next    = utf8_pkg::REPLACEMENT;
    if (seq_open && is_cont) begin
      if (({1'b0, held_cont} + 3'd1) >= {1'b0, need}) begin
        count_next         = utf8_pkg::CNT_W'(1);
        last_value_next    = utf8_pkg::finish_value(need, shifted);
        held_lead_next     = '0;
        partial_value_next = '0;
        held_cont_next     = '0;
        seq_open_next      = 1'b0;
      end else if (s_tlast) begin
        // open at end of text: lead, every held continuation and this byte
        count_next         = {1'b0, held_cont} + utf8_pkg::CNT_W'(2);
        held_lead_next     = '0;
        partial_value_next = '0;
        held_cont_next     = '0;
        seq_open_next      = 1'b0;
      end else begin
        partial_value_next = shifted;
        held_cont_next     = held_cont + 2'd1;
      end
    end else begin
      // a broken sequence is flushed first, then the byte is parsed afresh
      held_lead_next     = '0;
      partial_value_next = '0;
      held_cont_next     = '0;
      seq_open_next      = 1'b0;
      count_next         = base;
      if (!s_tdata[7]) begin
        count_next      = base + utf8_pkg::CNT_W'(1);
        last_value_next = {13'd0, s_tdata};
      end else if (s_tdata[7:5] == 3'b110 || s_tdata[7:4] == 4'b1110 ||
                   s_tdata[7:3] == 5'b11110) begin
        if (s_tlast) begin
          count_next = base + utf8_pkg::CNT_W'(1);
        end else begin
          held_lead_next = s_tdata;
          seq_open_next  = 1'b1;
          if (s_tdata[7:5] == 3'b110) begin
            partial_value_next = {16'd0, s_tdata[4:0]};
          end else if (s_tdata[7:4] == 4'b1110) begin
            partial_value_next = {17'd0, s_tdata[3:0]};
          end else begin
            partial_value_next = {18'd0, s_tdata[2:0]};
          end
        end
      end else begin
        // stray continuation or lead from f8 up
        count_next = base + utf8_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead     <= '0;
      partial_value <= '0;
      held_cont     <= '0;
      seq_open      <= 1'b0;
      out_valid     <= 1'b0;
      remaining     <= '0;
    end else begin
      if (in_xfer) begin
        held_lead     <= held_lead_next;
        partial_value <= partial_value_next;
        held_cont     <= held_cont_next;
        seq_open      <= seq_open_next;
        out_valid     <= (count_next != '0);
        remaining     <= count_next;
      end else if (out_xfer) begin
        remaining <= remaining - utf8_pkg::CNT_W'(1);
        out_valid <= !final_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      last_value <= last_value_next;
      out_eot    <= s_tlast;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, final_res ? last_value : utf8_pkg::REPLACEMENT};
  assign m_tlast  = final_res;
  assign m_tuser  = final_res && out_eot;

endmodule

// ===== rtl/utf8_checker.sv =====
// port-level assertions for the utf-8 stream decoder and their bind
`timescale 1ns / 1ps

module utf8_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("stalled result changed");

  // input only waits behind a pending result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // text done only on the last result of a byte
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("text done away from end of run");

  // results before the last of a run are replacements
  a_repl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata == {3'd0, utf8_pkg::REPLACEMENT})
    else $error("non-final result is not a replacement");

  // code point in range with zero padding
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:21] == 3'd0 && m_tdata[20:0] <= utf8_pkg::MAX_CP)
    else $error("code point out of range");

endmodule

bind utf8_stream_decoder utf8_checker u_utf8_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
